/* rtl/cdq_pkg.sv */
// ---------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants of the circular ring deque.
// ---------------------------------------------------------------------------
package cdq_pkg;

	localparam int DEPTH   = 64;  // ring slots; count field caps it below 128
	localparam int CNT_W   = 7;   // capacity, count and wrap arithmetic
	localparam int DATA_W  = 32;
	localparam int OUT_W   = 80;  // result fields packed, padded to bytes
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [CNT_W-1:0]  CAP_RESET = 7'd64;
	localparam logic [DATA_W-1:0] EMPTY_VAL = 32'hFFFF_FFFF;

	// register word index (paddr above the byte offset)
	localparam logic [PADDR_W-3:0] REG_CAPACITY = 1'b0;

	typedef enum logic [1:0] {
		KIND_INS_FRONT = 2'd0,
		KIND_INS_REAR  = 2'd1,
		KIND_DEL_FRONT = 2'd2,
		KIND_DEL_REAR  = 2'd3
	} kind_t;

	// from the register block to the queue control
	typedef struct packed {
		logic [CNT_W-1:0] cap_eff;
		logic             clear;
	} cfg_t;

endpackage

/* rtl/cdq_ram.sv */
// ---------------------------------------------------------------------------
// cdq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/cdq_cfg.sv */
// ---------------------------------------------------------------------------
// cdq_cfg
// APB register block: capacity register, saturated limit, queue clear.
// ---------------------------------------------------------------------------
module cdq_cfg
	import cdq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [CNT_W-1:0] cap_q;
	logic             sel_cap;
	logic             wr_cap;

	assign pready  = 1'b1;
	assign sel_cap = (paddr[PADDR_W-1:2] == REG_CAPACITY);
	assign wr_cap  = psel && penable && pwrite && sel_cap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (wr_cap) begin
			cap_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = sel_cap ? {{(PDATA_W-CNT_W){1'b0}}, cap_q} : '0;

	// limit saturates to 1..DEPTH
	always_comb begin
		if (cap_q == '0) begin
			cfg.cap_eff = CNT_W'(1);
		end else if (int'(cap_q) > DEPTH) begin
			cfg.cap_eff = CNT_W'(DEPTH);
		end else begin
			cfg.cap_eff = cap_q;
		end
		cfg.clear = wr_cap;
	end

endmodule

/* rtl/circular_ring_deque.sv */
// ---------------------------------------------------------------------------
// circular_ring_deque
// Bounded double-ended queue kept in a ring RAM of configurable capacity.
// ---------------------------------------------------------------------------
// Usage:
//   s_* channel takes one request item: s_tuser is the kind (insert front,
//   insert rear, delete front, delete rear), s_tdata the value to insert.
//   m_* channel returns one result item per request: ok, front and rear
//   values (-1 when empty), count, empty and full.
//   APB register 0 (byte 0) is the capacity; writing it empties the queue.
//   Write it only while no item is in flight.
// Timing:
//   A request passes through the accept cycle, which writes or reads the ring
//   RAM, and the next cycle, which takes the RAM read data and loads the result
//   register. No new request is accepted while one is in flight.
//   Front and rear values are cached in registers; the RAM is read only on a
//   successful delete, for the value at the new end.
// Reset:
//   Queue empty, capacity 64. The ring RAM is not cleared.
// Stall:
//   The result register holds while m_tready is low, and no new item is
//   accepted until it can be taken.
// ---------------------------------------------------------------------------
module circular_ring_deque
	import cdq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [DATA_W-1:0]  s_tdata,   // [31:0] value
	input  logic [1:0]         s_tuser,   // [1:0] kind
	output logic               m_tvalid,
	input  logic               m_tready,
	// [0] ok, [32:1] front_value, [64:33] rear_value, [71:65] count,
	// [72] is_empty, [73] is_full, [79:74] zero
	output logic [OUT_W-1:0]   m_tdata,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cfg_t cfg;

	logic [AW-1:0]     head_q, tail_q;
	logic [CNT_W-1:0]  fill_q;
	logic [DATA_W-1:0] front_q, rear_q;

	logic              busy_s1, ok_s1, ld_front_s1, ld_rear_s1;
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;

	logic              s_accept;
	kind_t             kind;
	logic [CNT_W-1:0]  cap_m1, h7, t7, head_nx, tail_nx;
	logic [AW-1:0]     head_d, tail_d;
	logic [CNT_W-1:0]  fill_d;
	logic              do_ins, do_del, ok_d;
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [DATA_W-1:0] ram_rdata;
	logic [DATA_W-1:0] front_nx, rear_nx;
	logic              empty_nx;

	cdq_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cdq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (s_tdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// one request in flight; the result register must be free next cycle
	assign s_tready = !busy_s1 && (!m_tvalid_q || m_tready);
	assign s_accept = s_tvalid && s_tready;
	assign kind     = kind_t'(s_tuser);

	// wrap arithmetic in count width: indices stay below the limit
	assign cap_m1  = cfg.cap_eff - CNT_W'(1);
	assign h7      = CNT_W'(head_q);
	assign t7      = CNT_W'(tail_q);

	always_comb begin
		head_nx   = h7;
		tail_nx   = t7;
		fill_d    = fill_q;
		do_ins    = 1'b0;
		do_del    = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = '0;
		ram_raddr = '0;
		case (kind)
			KIND_INS_FRONT, KIND_INS_REAR: begin
				do_ins = (fill_q < cfg.cap_eff);
				if (fill_q == '0) begin
					head_nx = '0;
					tail_nx = '0;
				end else if (kind == KIND_INS_FRONT) begin
					head_nx = (h7 == '0) ? cap_m1 : h7 - CNT_W'(1);
				end else begin
					tail_nx = (t7 >= cap_m1) ? '0 : t7 + CNT_W'(1);
				end
				fill_d    = fill_q + CNT_W'(1);
				ram_we    = s_accept && do_ins;
				ram_waddr = (kind == KIND_INS_FRONT) ? AW'(head_nx) : AW'(tail_nx);
			end
			KIND_DEL_FRONT, KIND_DEL_REAR: begin
				do_del = (fill_q != '0);
				if (kind == KIND_DEL_FRONT) begin
					head_nx = (h7 >= cap_m1) ? '0 : h7 + CNT_W'(1);
				end else begin
					tail_nx = (t7 == '0) ? cap_m1 : t7 - CNT_W'(1);
				end
				fill_d    = fill_q - CNT_W'(1);
				ram_re    = s_accept && do_del;
				ram_raddr = (kind == KIND_DEL_FRONT) ? AW'(head_nx) : AW'(tail_nx);
			end
			default: begin
			end
		endcase
	end

	assign ok_d   = do_ins || do_del;
	assign head_d = AW'(head_nx);
	assign tail_d = AW'(tail_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			busy_s1     <= 1'b0;
			ok_s1       <= 1'b0;
			ld_front_s1 <= 1'b0;
			ld_rear_s1  <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			busy_s1 <= s_accept;
			if (s_accept) begin
				ok_s1       <= ok_d;
				ld_front_s1 <= do_del && (kind == KIND_DEL_FRONT);
				ld_rear_s1  <= do_del && (kind == KIND_DEL_REAR);
			end
			if (cfg.clear) begin
				head_q <= '0;
				tail_q <= '0;
				fill_q <= '0;
			end else if (s_accept && ok_d) begin
				head_q <= head_d;
				tail_q <= tail_d;
				fill_q <= fill_d;
			end
			if (busy_s1) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// cached end values: inserts update at accept, deletes from RAM data
	assign front_nx = ld_front_s1 ? ram_rdata : front_q;
	assign rear_nx  = ld_rear_s1  ? ram_rdata : rear_q;
	assign empty_nx = (fill_q == '0);

	always_ff @(posedge clk) begin
		if (s_accept && do_ins) begin
			if (fill_q == '0) begin
				front_q <= s_tdata;
				rear_q  <= s_tdata;
			end else if (kind == KIND_INS_FRONT) begin
				front_q <= s_tdata;
			end else begin
				rear_q <= s_tdata;
			end
		end else if (busy_s1) begin
			front_q <= front_nx;
			rear_q  <= rear_nx;
		end
		if (busy_s1) begin
			m_tdata_q <= {
				{(OUT_W - 3 - 2*DATA_W - CNT_W){1'b0}},
				(fill_q == cfg.cap_eff),
				empty_nx,
				fill_q,
				empty_nx ? EMPTY_VAL : rear_nx,
				empty_nx ? EMPTY_VAL : front_nx,
				ok_s1
			};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_fill_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cfg.cap_eff)
		else $error("fill count above capacity");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |=> m_tvalid)
		else $error("result not loaded after request");

	a_ram_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("ring read and write in the same cycle");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && do_ins && !cfg.clear) |=> fill_q == $past(fill_q) + CNT_W'(1))
		else $error("insert did not advance count");

endmodule
